@@ rtl/lu_decompose_and_solve_assert.svh @@
// Assertion helpers used by the checks in lu_decompose_and_solve.
`ifndef LU_DECOMPOSE_AND_SOLVE_ASSERT_SVH
`define LU_DECOMPOSE_AND_SOLVE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, muted in reset.
`define LDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, muted in reset.
`define LDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lds_pkg.sv @@
`timescale 1ns / 1ps

package lds_pkg;

    // Fraction bits of the fixed-point format.
    localparam int FRAC_BITS = 16;

    // Input modes.
    localparam logic MODE_MATRIX = 1'b0;
    localparam logic MODE_RHS    = 1'b1;

    // Result kinds.
    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_SOLUTION = 1'b1;

    // Register indexes, taken from address bit 2.
    localparam logic REG_MATRIX_SIZE = 1'b0;
    localparam logic REG_TINY_PIVOT  = 1'b1;

    typedef logic [4:0]  t_size;
    typedef logic [15:0] t_tiny;

endpackage

@@ rtl/lds_ram.sv @@
`timescale 1ns / 1ps

module lds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lu_decompose_and_solve.sv @@
`timescale 1ns / 1ps
// Run time is set by the single shared multiply-accumulate and the one-bit-per-cycle
// divider, for both a factorization and a solve.
// Throughput: one beat is taken per cycle while loading and not busy; a beat with last
// starts a run and busy stays high until its final result. No stall exists on results.
// Reset is synchronous, active low: it clears the sequencer, flags and outputs, not stores.
`include "lu_decompose_and_solve_assert.svh"

module lu_decompose_and_solve #(
    parameter int MAX_N       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command channel.
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [3:0]                    i_row,
    input  logic [3:0]                    i_col,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_last,
    // Result channel.
    output logic                          o_strobe,
    output logic                          o_kind,
    output logic [3:0]                    o_index,
    output logic signed [VALUE_WIDTH-1:0] o_result_value,
    output logic                          o_singular,
    output logic                          o_parity_negative,
    output logic                          o_saturated,
    output logic                          o_last_result,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // Widths that follow from the parameters. Rows are addressed with a power-of-two
    // stride so that a matrix address is simply {row, col}.
    localparam int VW   = VALUE_WIDTH;
    localparam int FB   = lds_pkg::FRAC_BITS;
    localparam int IW   = $clog2(MAX_N);
    localparam int NW   = $clog2(MAX_N + 1);
    localparam int AW   = 2 * IW;
    localparam int MW   = 2 * VW;
    localparam int DW   = VW + FB;
    localparam int DCW  = $clog2(DW + 1);
    localparam int MDEP = 1 << AW;
    localparam int RDEP = 1 << IW;

    localparam logic [VW-1:0] VMAX = {1'b0, {(VW - 1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW - 1){1'b0}}};
    localparam logic [NW-1:0] NMAX = NW'(MAX_N);

    // The sequencer. The factorization walks the rows for their scale, then each
    // column j: the upper part, the lower part with the pivot search, the row swap,
    // the pivot fix-up and the division of the lower column. The solve runs forward
    // substitution with the permutation, back substitution, and then emits the vector.
    // The multiply-accumulate and the divider are subroutines that return to r_ret.
    typedef enum logic [5:0] {
        S_IDLE,
        S_SC_RD, S_SC_TAKE,
        S_COL,
        S_U_LOOP, S_U_LOAD, S_U_WR,
        S_L_LOOP, S_L_LOAD, S_L_WR,
        S_P_M1, S_P_M2, S_P_CMP,
        S_SW_CHK, S_SW_RD1, S_SW_RD2, S_SW_W1, S_SW_W2,
        S_DG_RD, S_DG_CHK,
        S_DV_LOOP, S_DV_LOAD, S_DV_WR,
        S_COL_NEXT, S_ST_OUT,
        S_F_PIV, S_F_R2, S_F_R3, S_F_WR,
        S_B_RD, S_B_LOAD, S_B_DG, S_B_DIV, S_B_WR,
        S_E_RD, S_E_OUT,
        S_M_RDA, S_M_RDB, S_M_MUL, S_M_ACC,
        S_D_INIT, S_D_RUN, S_D_FIN
    } t_state;

    t_state r_state;
    t_state r_ret;

    // Configuration registers.
    lds_pkg::t_size r_msize;
    lds_pkg::t_tiny r_tiny;

    // Loop counters and run control.
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_i;
    logic [NW-1:0] r_j;
    logic [NW-1:0] r_k;
    logic [NW-1:0] r_khi;
    logic [NW-1:0] r_imax;
    logic [IW-1:0] r_ip;
    logic          r_solve;

    // Flags kept between runs.
    logic r_par;
    logic r_sing;
    logic r_sat;

    // Datapath registers.
    logic [VW-1:0] r_s;
    logic [VW-1:0] r_a;
    logic [VW-1:0] r_big;
    logic [VW-1:0] r_piv;
    logic [VW-1:0] r_num;
    logic [VW-1:0] r_den;
    logic [VW-1:0] r_bnum;
    logic [VW-1:0] r_bden;
    logic [MW-1:0] r_prod;
    logic [MW-1:0] r_p1;
    logic          r_pneg;

    // Divider registers.
    logic [VW-1:0]  r_dden;
    logic [VW-1:0]  r_dub;
    logic [VW-1:0]  r_drem;
    logic [DW-1:0]  r_dquo;
    logic [DCW-1:0] r_dcnt;
    logic           r_dneg;

    // Row scales and the pivot row of each column.
    logic [VW-1:0] r_scale [MAX_N];
    logic [IW-1:0] r_pivot [MAX_N];

    // Result registers.
    logic          r_strobe;
    logic          r_kind;
    logic [3:0]    r_index;
    logic [VW-1:0] r_value;
    logic          r_last;

    // Memory ports.
    logic          mat_we;
    logic [AW-1:0] mat_waddr;
    logic [VW-1:0] mat_wdata;
    logic [AW-1:0] mat_raddr;
    logic [VW-1:0] mat_rdata;
    logic          rhs_we;
    logic [IW-1:0] rhs_waddr;
    logic [VW-1:0] rhs_wdata;
    logic [IW-1:0] rhs_raddr;
    logic [VW-1:0] rhs_rdata;

    // Shared multiplier.
    logic [VW-1:0] mul_a;
    logic [VW-1:0] mul_b;
    logic [MW-1:0] mul_p;

    logic          accept;
    logic          cfg_write;
    logic [NW-1:0] n_act;
    logic [VW-1:0] tiny_v;
    logic          row_ok;
    logic          col_ok;

    // Product and difference of the accumulate step.
    logic [MW-FB-1:0] pm;
    logic [VW-1:0]    mul_lim;
    logic             mul_ovf;
    logic [VW-1:0]    mul_mag;
    logic [VW-1:0]    mul_val;
    logic [VW:0]      sub_d;
    logic             sub_ovf;
    logic [VW-1:0]    sub_val;

    // Divider step and final rounding.
    logic [VW:0]   div_t;
    logic          div_ge;
    logic [VW:0]   div_d;
    logic [VW-1:0] div_lim;
    logic          div_ovf;
    logic [VW-1:0] div_mag;
    logic [VW-1:0] div_val;

    logic [VW-1:0] sc_mag;
    logic [VW-1:0] sc_big;
    logic [VW-1:0] rs_i;

    function automatic logic [VW-1:0] f_mag(input logic [VW-1:0] x);
        return x[VW-1] ? VW'(~x + 1'b1) : x;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [NW-1:0] row,
                                             input logic [NW-1:0] col);
        return {row[IW-1:0], col[IW-1:0]};
    endfunction

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == lds_pkg::REG_TINY_PIVOT) ? 32'(r_tiny) : 32'(r_msize);

    // A size of 0 acts as 1, any size above MAX_N acts as MAX_N.
    always_comb begin
        if (r_msize == '0) begin
            n_act = NW'(1);
        end else if (32'(r_msize) > MAX_N) begin
            n_act = NMAX;
        end else begin
            n_act = NW'(r_msize);
        end
    end

    assign tiny_v = (r_tiny == '0) ? VW'(1) : VW'(r_tiny);
    assign row_ok = (32'(i_row) < MAX_N);
    assign col_ok = (32'(i_col) < MAX_N);
    assign rs_i   = r_scale[r_i[IW-1:0]];

    // Products are taken on magnitudes, so the sign travels separately.
    always_comb begin
        unique case (r_state)
            S_P_M1: begin
                mul_a = r_num;
                mul_b = r_bden;
            end
            S_P_M2: begin
                mul_a = r_bnum;
                mul_b = r_den;
            end
            default: begin
                mul_a = f_mag(r_a);
                mul_b = f_mag(r_solve ? rhs_rdata : mat_rdata);
            end
        endcase
    end

    assign mul_p = MW'(mul_a) * MW'(mul_b);

    // Truncated product, clipped to the signed range, then subtracted with clipping.
    assign pm      = r_prod[MW-1:FB];
    assign mul_lim = r_pneg ? VMIN : VMAX;
    assign mul_ovf = (pm > (MW - FB)'(mul_lim));
    assign mul_mag = mul_ovf ? mul_lim : pm[VW-1:0];
    assign mul_val = r_pneg ? VW'(~mul_mag + 1'b1) : mul_mag;
    assign sub_d   = {r_s[VW-1], r_s} - {mul_val[VW-1], mul_val};
    assign sub_ovf = sub_d[VW] ^ sub_d[VW-1];
    assign sub_val = sub_ovf ? (sub_d[VW] ? VMIN : VMAX) : sub_d[VW-1:0];

    // Restoring division, one quotient bit per cycle. The dividend is shifted out of
    // the top of r_dquo while quotient bits enter at the bottom.
    assign div_t   = {r_drem, r_dquo[DW-1]};
    assign div_ge  = (div_t >= {1'b0, r_dub});
    assign div_d   = div_t - {1'b0, r_dub};
    assign div_lim = r_dneg ? VMIN : VMAX;
    assign div_ovf = (r_dquo > DW'(div_lim));
    assign div_mag = div_ovf ? div_lim : r_dquo[VW-1:0];
    assign div_val = r_dneg ? VW'(~div_mag + 1'b1) : div_mag;

    assign sc_mag = f_mag(mat_rdata);
    assign sc_big = (sc_mag > r_big) ? sc_mag : r_big;

    // Memory addressing by state. A read of an entry is never issued in the cycle of its
    // write, so no forwarding path is needed.
    always_comb begin
        mat_we    = 1'b0;
        mat_waddr = f_addr(r_i, r_j);
        mat_wdata = r_s;
        mat_raddr = f_addr(r_i, r_j);
        rhs_we    = 1'b0;
        rhs_waddr = r_i[IW-1:0];
        rhs_wdata = r_s;
        rhs_raddr = r_i[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                mat_waddr = {IW'(i_row), IW'(i_col)};
                mat_wdata = i_value;
                mat_we    = accept && (i_mode == lds_pkg::MODE_MATRIX) && row_ok && col_ok;
                rhs_waddr = IW'(i_row);
                rhs_wdata = i_value;
                rhs_we    = accept && (i_mode == lds_pkg::MODE_RHS) && row_ok;
            end
            S_SC_RD:  mat_raddr = f_addr(r_i, r_k);
            S_U_WR:   mat_we = 1'b1;
            S_L_WR:   mat_we = 1'b1;
            S_SW_RD1: mat_raddr = f_addr(r_imax, r_k);
            S_SW_RD2: mat_raddr = f_addr(r_j, r_k);
            S_SW_W1: begin
                mat_we    = 1'b1;
                mat_waddr = f_addr(r_imax, r_k);
                mat_wdata = mat_rdata;
            end
            S_SW_W2: begin
                mat_we    = 1'b1;
                mat_waddr = f_addr(r_j, r_k);
                mat_wdata = r_a;
            end
            S_DG_RD:  mat_raddr = f_addr(r_j, r_j);
            S_DG_CHK: begin
                mat_we    = (mat_rdata == '0);
                mat_waddr = f_addr(r_j, r_j);
                mat_wdata = tiny_v;
            end
            S_DV_WR:  mat_we = 1'b1;
            S_F_PIV:  rhs_raddr = r_pivot[r_i[IW-1:0]];
            S_F_R3: begin
                rhs_we    = 1'b1;
                rhs_waddr = r_ip;
                rhs_wdata = rhs_rdata;
            end
            S_F_WR:   rhs_we = 1'b1;
            S_B_DG:   mat_raddr = f_addr(r_i, r_i);
            S_B_WR:   rhs_we = 1'b1;
            S_M_RDA:  mat_raddr = f_addr(r_i, r_k);
            S_M_RDB: begin
                mat_raddr = f_addr(r_k, r_j);
                rhs_raddr = r_k[IW-1:0];
            end
            default: begin
                mat_we = 1'b0;
                rhs_we = 1'b0;
            end
        endcase
    end

    lds_ram #(
        .WIDTH (VW),
        .DEPTH (MDEP)
    ) u_mat (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (mat_wdata),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    lds_ram #(
        .WIDTH (VW),
        .DEPTH (RDEP)
    ) u_rhs (
        .i_clk   (i_clk),
        .i_we    (rhs_we),
        .i_waddr (rhs_waddr),
        .i_wdata (rhs_wdata),
        .i_raddr (rhs_raddr),
        .o_rdata (rhs_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_msize  <= 5'd4;
            r_tiny   <= 16'd1;
            r_par    <= 1'b0;
            r_sing   <= 1'b0;
            r_sat    <= 1'b0;
            r_solve  <= 1'b0;
            r_strobe <= 1'b0;
            r_kind   <= lds_pkg::KIND_STATUS;
            r_index  <= '0;
            r_value  <= '0;
            r_last   <= 1'b0;
            r_n      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_khi    <= '0;
            r_imax   <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (cfg_write) begin
                if (paddr[2] == lds_pkg::REG_MATRIX_SIZE) begin
                    r_msize <= pwdata[4:0];
                end else begin
                    r_tiny <= pwdata[15:0];
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_last) begin
                        r_n   <= n_act;
                        r_sat <= 1'b0;
                        r_i   <= '0;
                        r_k   <= '0;
                        if (i_mode == lds_pkg::MODE_MATRIX) begin
                            r_par   <= 1'b0;
                            r_sing  <= 1'b0;
                            r_big   <= '0;
                            r_solve <= 1'b0;
                            r_state <= S_SC_RD;
                        end else begin
                            r_solve <= 1'b1;
                            r_state <= S_F_PIV;
                        end
                    end
                end

                // Largest magnitude of each row.
                S_SC_RD: r_state <= S_SC_TAKE;
                S_SC_TAKE: begin
                    if (NW'(r_k + 1'b1) == r_n) begin
                        r_scale[r_i[IW-1:0]] <= sc_big;
                        if (sc_big == '0) begin
                            r_sing <= 1'b1;
                        end
                        r_big <= '0;
                        r_k   <= '0;
                        r_i   <= NW'(r_i + 1'b1);
                        if (NW'(r_i + 1'b1) == r_n) begin
                            r_j     <= '0;
                            r_state <= S_COL;
                        end else begin
                            r_state <= S_SC_RD;
                        end
                    end else begin
                        r_big   <= sc_big;
                        r_k     <= NW'(r_k + 1'b1);
                        r_state <= S_SC_RD;
                    end
                end

                S_COL: begin
                    r_i     <= '0;
                    r_bnum  <= '0;
                    r_bden  <= VW'(1);
                    r_imax  <= r_j;
                    r_state <= S_U_LOOP;
                end

                // Rows above the diagonal.
                S_U_LOOP: r_state <= (r_i < r_j) ? S_U_LOAD : S_L_LOOP;
                S_U_LOAD: begin
                    r_s <= mat_rdata;
                    if (r_i == '0) begin
                        r_state <= S_U_WR;
                    end else begin
                        r_k     <= '0;
                        r_khi   <= r_i;
                        r_ret   <= S_U_WR;
                        r_state <= S_M_RDA;
                    end
                end
                S_U_WR: begin
                    r_i     <= NW'(r_i + 1'b1);
                    r_state <= S_U_LOOP;
                end

                // Rows on and below the diagonal, with the pivot search.
                S_L_LOOP: r_state <= (r_i < r_n) ? S_L_LOAD : S_SW_CHK;
                S_L_LOAD: begin
                    r_s <= mat_rdata;
                    if (r_j == '0) begin
                        r_state <= S_L_WR;
                    end else begin
                        r_k     <= '0;
                        r_khi   <= r_j;
                        r_ret   <= S_L_WR;
                        r_state <= S_M_RDA;
                    end
                end
                S_L_WR: begin
                    // A row of zero scale counts as ratio zero.
                    r_num   <= (rs_i != '0) ? f_mag(r_s) : '0;
                    r_den   <= (rs_i != '0) ? rs_i : VW'(1);
                    r_state <= S_P_M1;
                end
                S_P_M1: begin
                    r_prod  <= mul_p;
                    r_state <= S_P_M2;
                end
                S_P_M2: begin
                    r_p1    <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= S_P_CMP;
                end
                S_P_CMP: begin
                    // Cross-multiplied ratio compare; a tie goes to the later row.
                    if (r_p1 >= r_prod) begin
                        r_bnum <= r_num;
                        r_bden <= r_den;
                        r_imax <= r_i;
                    end
                    r_i     <= NW'(r_i + 1'b1);
                    r_state <= S_L_LOOP;
                end

                // Row interchange over the whole stored width.
                S_SW_CHK: begin
                    r_pivot[r_j[IW-1:0]] <= r_imax[IW-1:0];
                    r_k <= '0;
                    if (r_imax != r_j) begin
                        r_par <= !r_par;
                        r_scale[r_imax[IW-1:0]] <= r_scale[r_j[IW-1:0]];
                        r_state <= S_SW_RD1;
                    end else begin
                        r_state <= S_DG_RD;
                    end
                end
                S_SW_RD1: r_state <= S_SW_RD2;
                S_SW_RD2: begin
                    r_a     <= mat_rdata;
                    r_state <= S_SW_W1;
                end
                S_SW_W1: r_state <= S_SW_W2;
                S_SW_W2: begin
                    r_k     <= NW'(r_k + 1'b1);
                    r_state <= (NW'(r_k + 1'b1) == NMAX) ? S_DG_RD : S_SW_RD1;
                end

                // An exactly zero pivot is replaced by the tiny value.
                S_DG_RD: r_state <= S_DG_CHK;
                S_DG_CHK: begin
                    r_piv   <= (mat_rdata == '0) ? tiny_v : mat_rdata;
                    r_i     <= NW'(r_j + 1'b1);
                    r_state <= S_DV_LOOP;
                end

                // Scale the column below the pivot.
                S_DV_LOOP: r_state <= (r_i < r_n) ? S_DV_LOAD : S_COL_NEXT;
                S_DV_LOAD: begin
                    r_s     <= mat_rdata;
                    r_dden  <= r_piv;
                    r_ret   <= S_DV_WR;
                    r_state <= S_D_INIT;
                end
                S_DV_WR: begin
                    r_i     <= NW'(r_i + 1'b1);
                    r_state <= S_DV_LOOP;
                end

                S_COL_NEXT: begin
                    r_j     <= NW'(r_j + 1'b1);
                    r_state <= (NW'(r_j + 1'b1) == r_n) ? S_ST_OUT : S_COL;
                end
                S_ST_OUT: begin
                    r_strobe <= 1'b1;
                    r_kind   <= lds_pkg::KIND_STATUS;
                    r_index  <= '0;
                    r_value  <= '0;
                    r_last   <= 1'b1;
                    r_state  <= S_IDLE;
                end

                // Forward substitution, applying the permutation on the way.
                S_F_PIV: begin
                    r_ip    <= r_pivot[r_i[IW-1:0]];
                    r_state <= S_F_R2;
                end
                S_F_R2: begin
                    r_s     <= rhs_rdata;
                    r_state <= S_F_R3;
                end
                S_F_R3: begin
                    if (r_i == '0) begin
                        r_state <= S_F_WR;
                    end else begin
                        r_k     <= '0;
                        r_khi   <= r_i;
                        r_ret   <= S_F_WR;
                        r_state <= S_M_RDA;
                    end
                end
                S_F_WR: begin
                    if (NW'(r_i + 1'b1) == r_n) begin
                        r_state <= S_B_RD;
                    end else begin
                        r_i     <= NW'(r_i + 1'b1);
                        r_state <= S_F_PIV;
                    end
                end

                // Back substitution, bottom row first.
                S_B_RD: r_state <= S_B_LOAD;
                S_B_LOAD: begin
                    r_s <= rhs_rdata;
                    if (NW'(r_i + 1'b1) == r_n) begin
                        r_state <= S_B_DG;
                    end else begin
                        r_k     <= NW'(r_i + 1'b1);
                        r_khi   <= r_n;
                        r_ret   <= S_B_DG;
                        r_state <= S_M_RDA;
                    end
                end
                S_B_DG: r_state <= S_B_DIV;
                S_B_DIV: begin
                    r_dden  <= mat_rdata;
                    r_ret   <= S_B_WR;
                    r_state <= S_D_INIT;
                end
                S_B_WR: begin
                    if (r_i == '0) begin
                        r_state <= S_E_RD;
                    end else begin
                        r_i     <= NW'(r_i - 1'b1);
                        r_state <= S_B_RD;
                    end
                end

                // Emit the solution vector.
                S_E_RD: r_state <= S_E_OUT;
                S_E_OUT: begin
                    r_strobe <= 1'b1;
                    r_kind   <= lds_pkg::KIND_SOLUTION;
                    r_index  <= 4'(r_i);
                    r_value  <= rhs_rdata;
                    r_last   <= (NW'(r_i + 1'b1) == r_n);
                    r_i      <= NW'(r_i + 1'b1);
                    r_state  <= (NW'(r_i + 1'b1) == r_n) ? S_IDLE : S_E_RD;
                end

                // Multiply-accumulate: r_s -= A[i][k] * B[k] for k in [r_k, r_khi).
                S_M_RDA: r_state <= S_M_RDB;
                S_M_RDB: begin
                    r_a     <= mat_rdata;
                    r_state <= S_M_MUL;
                end
                S_M_MUL: begin
                    r_prod  <= mul_p;
                    r_pneg  <= r_a[VW-1] ^ (r_solve ? rhs_rdata[VW-1] : mat_rdata[VW-1]);
                    r_state <= S_M_ACC;
                end
                S_M_ACC: begin
                    r_s <= sub_val;
                    if (mul_ovf || sub_ovf) begin
                        r_sat <= 1'b1;
                    end
                    r_k     <= NW'(r_k + 1'b1);
                    r_state <= (NW'(r_k + 1'b1) == r_khi) ? r_ret : S_M_RDA;
                end

                // Divider: r_s = r_s / r_dden.
                S_D_INIT: begin
                    if (r_dden == '0) begin
                        // Zero over zero is zero; otherwise clip toward the numerator sign.
                        if (r_s != '0) begin
                            r_s   <= r_s[VW-1] ? VMIN : VMAX;
                            r_sat <= 1'b1;
                        end
                        r_state <= r_ret;
                    end else begin
                        r_dneg  <= r_s[VW-1] ^ r_dden[VW-1];
                        r_dub   <= f_mag(r_dden);
                        r_dquo  <= {f_mag(r_s), {FB{1'b0}}};
                        r_drem  <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_D_RUN;
                    end
                end
                S_D_RUN: begin
                    r_drem  <= div_ge ? div_d[VW-1:0] : div_t[VW-1:0];
                    r_dquo  <= {r_dquo[DW-2:0], div_ge};
                    r_dcnt  <= DCW'(r_dcnt + 1'b1);
                    r_state <= (r_dcnt == DCW'(DW - 1)) ? S_D_FIN : S_D_RUN;
                end
                S_D_FIN: begin
                    r_s <= div_val;
                    if (div_ovf) begin
                        r_sat <= 1'b1;
                    end
                    r_state <= r_ret;
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe          = r_strobe;
    assign o_kind            = r_kind;
    assign o_index           = r_index;
    assign o_result_value    = r_value;
    assign o_singular        = r_sing;
    assign o_parity_negative = r_par;
    assign o_saturated       = r_sat;
    assign o_last_result     = r_last && r_strobe;

    // A result always comes out of a run that was under way the cycle before.
    `LDS_ASSERT_IMP(a_strobe_after_run, o_strobe, $past(busy), "result beat without a run")
    // The end-of-run mark only rides on a result beat.
    `LDS_ASSERT_IMP(a_last_on_strobe, o_last_result, o_strobe, "last mark without a beat")
    // A status beat is the only beat of a factorization.
    `LDS_ASSERT_IMP(a_status_is_last, o_strobe && (o_kind == lds_pkg::KIND_STATUS),
        o_last_result, "status beat not marked last")
    // A beat flagged last starts a run at once.
    `LDS_ASSERT_NXT(a_last_starts_run, start && !busy && i_last, busy,
        "final element did not start a run")

endmodule
